// File: rtl/core/twi_pkg.sv
package twi_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_EVENT = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_SEND    = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_RX_ACK  = 3'd4,
        CMD_RX_NACK = 3'd5,
        CMD_HALT    = 3'd6
    } t_command;

    localparam logic [3:0] EV_START        = 4'd0;
    localparam logic [3:0] EV_REPSTART     = 4'd1;
    localparam logic [3:0] EV_WR_ADDR_ACK  = 4'd2;
    localparam logic [3:0] EV_WR_DATA_ACK  = 4'd3;
    localparam logic [3:0] EV_RD_ADDR_ACK  = 4'd4;
    localparam logic [3:0] EV_RD_DATA_ACK  = 4'd5;
    localparam logic [3:0] EV_RD_DATA_NACK = 4'd6;
    localparam logic [3:0] EV_ARB_LOST     = 4'd7;
    localparam logic [3:0] EV_ERROR        = 4'd8;

    typedef struct packed {
        t_action     action;
        logic [3:0]  index;
        logic [7:0]  value;
        logic [4:0]  tx_count;
        logic [4:0]  rx_count;
        logic [3:0]  bus_event;
        logic [7:0]  rx_data;
    } t_in_word;

    typedef struct packed {
        t_command    command;
        logic [7:0]  tx_data;
        logic        busy_res;
        logic        failed;
        logic [7:0]  read_data;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// File: rtl/core/twi_in_reg.sv
module twi_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  twi_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic              o_valid,
    output twi_pkg::t_in_word o_word
);
    import twi_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

endmodule

// File: rtl/core/twi_seq_core.sv
module twi_seq_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  twi_pkg::t_in_word  i_word,
    output twi_pkg::t_out_word o_result
);
    import twi_pkg::*;

    logic [7:0]       r_tx_store [BUF_DEPTH];
    logic [7:0]       r_rx_store [BUF_DEPTH];
    logic [CNT_W-1:0] r_tx_len, n_tx_len;
    logic [CNT_W-1:0] r_rx_len, n_rx_len;
    logic [CNT_W-1:0] r_tx_pos, n_tx_pos;
    logic [CNT_W-1:0] r_rx_pos, n_rx_pos;
    logic             r_busy, n_busy;
    logic             r_failed, n_failed;

    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic             is_start;
    logic [CNT_W-1:0] tx_pos_eff;
    logic [CNT_W-1:0] rx_pos_inc;
    logic             rx_room;
    logic             tx_we;
    logic             set_rd_bit;
    logic             rx_we;

    function automatic t_command ack_or_nack(input logic [CNT_W-1:0] pos,
                                             input logic [CNT_W-1:0] len);
        logic [CNT_W:0] pos_next;
        pos_next = {1'b0, pos} + 1'b1;
        return (pos_next < {1'b0, len}) ? CMD_RX_ACK : CMD_RX_NACK;
    endfunction

    assign idx_ok     = int'(i_word.index) < BUF_DEPTH;
    assign idx        = IDX_W'(i_word.index);
    assign is_start   = (i_word.bus_event == EV_START) || (i_word.bus_event == EV_REPSTART);
    assign tx_pos_eff = is_start ? '0 : r_tx_pos;
    assign rx_room    = r_rx_pos < CNT_W'(BUF_DEPTH);
    assign rx_pos_inc = rx_room ? r_rx_pos + 1'b1 : r_rx_pos;

    always_comb begin
        n_tx_len   = r_tx_len;
        n_rx_len   = r_rx_len;
        n_tx_pos   = r_tx_pos;
        n_rx_pos   = r_rx_pos;
        n_busy     = r_busy;
        n_failed   = r_failed;
        tx_we      = 1'b0;
        set_rd_bit = 1'b0;
        rx_we      = 1'b0;
        o_result.command   = CMD_NONE;
        o_result.tx_data   = 8'd0;
        o_result.read_data = 8'd0;

        unique case (i_word.action)
            ACT_LOAD: begin
                tx_we = !r_busy && idx_ok;
            end
            ACT_START: begin
                if (!r_busy) begin
                    n_tx_len = (i_word.tx_count > BUF_DEPTH) ? CNT_W'(BUF_DEPTH)
                                                             : CNT_W'(i_word.tx_count);
                    n_rx_len = (i_word.rx_count > BUF_DEPTH) ? CNT_W'(BUF_DEPTH)
                                                             : CNT_W'(i_word.rx_count);
                    n_tx_pos = '0;
                    n_rx_pos = '0;
                    n_failed = 1'b0;
                    n_busy   = 1'b1;
                    o_result.command = CMD_START;
                end
            end
            ACT_EVENT: begin
                if (r_busy) begin
                    unique case (i_word.bus_event) inside
                        EV_START, EV_REPSTART, EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
                            n_tx_pos = tx_pos_eff;
                            if (is_start) begin
                                n_rx_pos = '0;
                            end
                            if (tx_pos_eff < r_tx_len) begin
                                o_result.tx_data = r_tx_store[tx_pos_eff[IDX_W-1:0]];
                                n_tx_pos         = tx_pos_eff + 1'b1;
                                o_result.command = CMD_SEND;
                            end else if (r_rx_len != '0) begin
                                set_rd_bit       = 1'b1;
                                n_tx_len         = CNT_W'(1);
                                o_result.command = CMD_START;
                            end else begin
                                n_busy           = 1'b0;
                                o_result.command = CMD_STOP;
                            end
                        end
                        EV_RD_DATA_ACK: begin
                            rx_we            = rx_room;
                            n_rx_pos         = rx_pos_inc;
                            o_result.command = ack_or_nack(rx_pos_inc, r_rx_len);
                        end
                        EV_RD_ADDR_ACK: begin
                            o_result.command = ack_or_nack(r_rx_pos, r_rx_len);
                        end
                        EV_RD_DATA_NACK: begin
                            rx_we            = rx_room;
                            n_busy           = 1'b0;
                            o_result.command = CMD_STOP;
                        end
                        EV_ARB_LOST: begin
                            o_result.command = CMD_START;
                        end
                        default: begin
                            n_busy           = 1'b0;
                            n_failed         = 1'b1;
                            o_result.command = CMD_HALT;
                        end
                    endcase
                end
            end
            ACT_READ: begin
                if (idx_ok) begin
                    o_result.read_data = r_rx_store[idx];
                end
            end
        endcase

        o_result.busy_res = n_busy;
        o_result.failed   = n_failed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_len <= '0;
            r_rx_len <= '0;
            r_tx_pos <= '0;
            r_rx_pos <= '0;
            r_busy   <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_fire) begin
            r_tx_len <= n_tx_len;
            r_rx_len <= n_rx_len;
            r_tx_pos <= n_tx_pos;
            r_rx_pos <= n_rx_pos;
            r_busy   <= n_busy;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && tx_we) begin
            r_tx_store[idx] <= i_word.value;
        end else if (i_fire && set_rd_bit) begin
            r_tx_store[0][0] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && rx_we) begin
            r_rx_store[r_rx_pos[IDX_W-1:0]] <= i_word.rx_data;
        end
    end

endmodule

// File: rtl/core/twi_out_reg.sv
module twi_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  twi_pkg::t_out_word  i_result,
    output twi_pkg::t_stage_ctl o_ctl,
    output logic                o_valid,
    input  logic                i_stall,
    output twi_pkg::t_out_word  o_word
);
    import twi_pkg::*;

    logic      r_valid;
    t_out_word r_word;
    logic      ready;

    assign ready         = !(r_valid && i_stall);
    assign o_ctl.advance = ready;
    assign o_ctl.valid   = i_valid && ready;
    assign o_valid       = r_valid;
    assign o_word        = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready) begin
            r_word <= i_result;
        end
    end

endmodule

// File: rtl/core/twi_master_transaction_sequencer.sv
// I2C master write-then-read sequencer. Each input word (load, start, bus event or
// read-back) yields exactly one result word. Throughput is one word per cycle while the
// output is not stalled; each word passes through the input register and the result
// register, with the sequencing logic between them. Both 16-byte buffers and all
// counters live in flip-flops and update as a word leaves the input register. Buffer
// entries hold no defined value until written; sending or reading back one that was
// never written returns an arbitrary byte.
module twi_master_transaction_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  twi_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output twi_pkg::t_out_word o_out_data
);
    import twi_pkg::*;

    logic       held_valid;
    t_in_word   held_word;
    t_out_word  result;
    t_stage_ctl ctl;

    twi_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_word    (i_in_data),
        .i_advance (ctl.advance),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    twi_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (ctl.valid),
        .i_word   (held_word),
        .o_result (result)
    );

    twi_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .i_result (result),
        .o_ctl    (ctl),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_out_data)
    );

endmodule
